### src/cpu_alu_pkg.sv
package cpu_alu_pkg;

  localparam int unsigned OP_W    = 5;
  localparam int unsigned WORD_W  = 16;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned BIDX_W  = 3;
  localparam int unsigned COND_W  = 3;
  localparam int unsigned FLAGS_W = 4;

  localparam int unsigned FLAG_Z = 3;
  localparam int unsigned FLAG_N = 2;
  localparam int unsigned FLAG_H = 1;
  localparam int unsigned FLAG_C = 0;

  typedef enum logic [OP_W-1:0] {
    OP_ADD   = 5'd0,
    OP_ADC   = 5'd1,
    OP_SUB   = 5'd2,
    OP_AND   = 5'd3,
    OP_XOR   = 5'd4,
    OP_OR    = 5'd5,
    OP_CP    = 5'd6,
    OP_INC   = 5'd7,
    OP_DEC   = 5'd8,
    OP_ADD16 = 5'd9,
    OP_RL    = 5'd10,
    OP_RLC   = 5'd11,
    OP_RR    = 5'd12,
    OP_RRC   = 5'd13,
    OP_SLA   = 5'd14,
    OP_SRA   = 5'd15,
    OP_SRL   = 5'd16,
    OP_SWAP  = 5'd17,
    OP_BIT   = 5'd18,
    OP_RES   = 5'd19,
    OP_SET   = 5'd20,
    OP_COND  = 5'd21
  } alu_op_t;

  typedef enum logic [COND_W-1:0] {
    CC_ALWAYS = 3'd0,
    CC_C      = 3'd1,
    CC_NC     = 3'd2,
    CC_Z      = 3'd3,
    CC_NZ     = 3'd4
  } alu_cond_t;

  typedef struct packed {
    alu_op_t             op;
    logic [WORD_W-1:0]   a_value;
    logic [WORD_W-1:0]   b_value;
    logic [BIDX_W-1:0]   bit_index;
    logic                update_zero;
    alu_cond_t           cond;
    logic [FLAGS_W-1:0]  flags_in;
  } alu_req_t;

  typedef struct packed {
    logic [WORD_W-1:0]   result;
    logic [FLAGS_W-1:0]  flags_out;
    logic                cond_met;
  } alu_rsp_t;

endpackage

### src/cpu_alu_if.sv
interface cpu_alu_req_if;
  logic                                valid;
  logic                                ready;
  logic [cpu_alu_pkg::OP_W-1:0]        op;
  logic [cpu_alu_pkg::WORD_W-1:0]      a_value;
  logic [cpu_alu_pkg::WORD_W-1:0]      b_value;
  logic [cpu_alu_pkg::BIDX_W-1:0]      bit_index;
  logic                                update_zero;
  logic [cpu_alu_pkg::COND_W-1:0]      cond;
  logic [cpu_alu_pkg::FLAGS_W-1:0]     flags_in;

  modport source (output valid, op, a_value, b_value, bit_index, update_zero, cond,
                  flags_in, input ready);
  modport sink (input valid, op, a_value, b_value, bit_index, update_zero, cond,
                flags_in, output ready);
endinterface

interface cpu_alu_rsp_if;
  logic                                valid;
  logic                                ready;
  logic [cpu_alu_pkg::WORD_W-1:0]      result;
  logic [cpu_alu_pkg::FLAGS_W-1:0]     flags_out;
  logic                                cond_met;

  modport source (output valid, result, flags_out, cond_met, input ready);
  modport sink (input valid, result, flags_out, cond_met, output ready);
endinterface

### src/cpu_alu_core.sv
module cpu_alu_core (
  input  cpu_alu_pkg::alu_req_t req,
  output cpu_alu_pkg::alu_rsp_t rsp
);

  logic [cpu_alu_pkg::BYTE_W-1:0]  a;
  logic [cpu_alu_pkg::BYTE_W-1:0]  b;
  logic                            cin;
  logic                            cadd;
  logic [cpu_alu_pkg::BYTE_W:0]    sum9;
  logic [4:0]                      hsum;
  logic [cpu_alu_pkg::BYTE_W:0]    dif9;
  logic [cpu_alu_pkg::WORD_W:0]    sum17;
  logic [12:0]                     hsum16;
  logic [cpu_alu_pkg::BYTE_W-1:0]  mask;
  logic [cpu_alu_pkg::BYTE_W-1:0]  r8;
  logic [cpu_alu_pkg::WORD_W-1:0]  res;
  logic [cpu_alu_pkg::FLAGS_W-1:0] f;
  logic                            met;

  assign a    = req.a_value[cpu_alu_pkg::BYTE_W-1:0];
  assign b    = req.b_value[cpu_alu_pkg::BYTE_W-1:0];
  assign cin  = req.flags_in[cpu_alu_pkg::FLAG_C];
  assign cadd = (req.op == cpu_alu_pkg::OP_ADC) ? cin : 1'b0;

  assign sum9   = {1'b0, a} + {1'b0, b} + {8'd0, cadd};
  assign hsum   = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, cadd};
  assign dif9   = {1'b0, a} - {1'b0, b};
  assign sum17  = {1'b0, req.a_value} + {1'b0, req.b_value};
  assign hsum16 = {1'b0, req.a_value[11:0]} + {1'b0, req.b_value[11:0]};
  assign mask   = 8'd1 << req.bit_index;

  always_comb begin
    case (req.cond)
      cpu_alu_pkg::CC_ALWAYS: met = 1'b1;
      cpu_alu_pkg::CC_C:      met = req.flags_in[cpu_alu_pkg::FLAG_C];
      cpu_alu_pkg::CC_NC:     met = ~req.flags_in[cpu_alu_pkg::FLAG_C];
      cpu_alu_pkg::CC_Z:      met = req.flags_in[cpu_alu_pkg::FLAG_Z];
      cpu_alu_pkg::CC_NZ:     met = ~req.flags_in[cpu_alu_pkg::FLAG_Z];
      default:                met = 1'b0;
    endcase
  end

  always_comb begin
    r8  = '0;
    res = '0;
    f   = req.flags_in;
    case (req.op)
      cpu_alu_pkg::OP_ADD, cpu_alu_pkg::OP_ADC: begin
        r8 = sum9[7:0];
        f  = {r8 == 8'd0, 1'b0, hsum[4], sum9[8]};
      end
      cpu_alu_pkg::OP_SUB, cpu_alu_pkg::OP_CP: begin
        r8 = dif9[7:0];
        f  = {r8 == 8'd0, 1'b1, a[3:0] < b[3:0], dif9[8]};
      end
      cpu_alu_pkg::OP_AND: begin
        r8 = a & b;
        f  = {r8 == 8'd0, 1'b0, 1'b1, 1'b0};
      end
      cpu_alu_pkg::OP_XOR: begin
        r8 = a ^ b;
        f  = {r8 == 8'd0, 3'b000};
      end
      cpu_alu_pkg::OP_OR: begin
        r8 = a | b;
        f  = {r8 == 8'd0, 3'b000};
      end
      cpu_alu_pkg::OP_INC: begin
        r8 = a + 8'd1;
        f  = {r8 == 8'd0, 1'b0, a[3:0] == 4'hF, cin};
      end
      cpu_alu_pkg::OP_DEC: begin
        r8 = a - 8'd1;
        f  = {r8 == 8'd0, 1'b1, a[3:0] == 4'h0, cin};
      end
      cpu_alu_pkg::OP_RL: begin
        r8 = {a[6:0], cin};
        f  = {r8 == 8'd0, 2'b00, a[7]};
      end
      cpu_alu_pkg::OP_RLC: begin
        r8 = {a[6:0], a[7]};
        f  = {r8 == 8'd0, 2'b00, a[7]};
      end
      cpu_alu_pkg::OP_RR: begin
        r8 = {cin, a[7:1]};
        f  = {r8 == 8'd0, 2'b00, a[0]};
      end
      cpu_alu_pkg::OP_RRC: begin
        r8 = {a[0], a[7:1]};
        f  = {r8 == 8'd0, 2'b00, a[0]};
      end
      cpu_alu_pkg::OP_SLA: begin
        r8 = {a[6:0], 1'b0};
        f  = {r8 == 8'd0, 2'b00, a[7]};
      end
      cpu_alu_pkg::OP_SRA: begin
        r8 = {a[7], a[7:1]};
        f  = {r8 == 8'd0, 2'b00, a[0]};
      end
      cpu_alu_pkg::OP_SRL: begin
        r8 = {1'b0, a[7:1]};
        f  = {r8 == 8'd0, 2'b00, a[0]};
      end
      cpu_alu_pkg::OP_SWAP: begin
        r8 = {a[3:0], a[7:4]};
        f  = {r8 == 8'd0, 3'b000};
      end
      cpu_alu_pkg::OP_RES: r8 = a & ~mask;
      cpu_alu_pkg::OP_SET: r8 = a | mask;
      default: r8 = '0;
    endcase

    case (req.op)
      cpu_alu_pkg::OP_CP, cpu_alu_pkg::OP_BIT: res = req.a_value;
      cpu_alu_pkg::OP_ADD16: res = sum17[cpu_alu_pkg::WORD_W-1:0];
      default: res = {{(cpu_alu_pkg::WORD_W-cpu_alu_pkg::BYTE_W){1'b0}}, r8};
    endcase

    case (req.op)
      cpu_alu_pkg::OP_ADD16: begin
        f = {req.update_zero ? (sum17[cpu_alu_pkg::WORD_W-1:0] == '0)
                             : req.flags_in[cpu_alu_pkg::FLAG_Z],
             1'b0, hsum16[12], sum17[cpu_alu_pkg::WORD_W]};
      end
      cpu_alu_pkg::OP_BIT: f = {~a[req.bit_index], 1'b0, 1'b1, cin};
      default: ;
    endcase
  end

  assign rsp.result    = res;
  assign rsp.flags_out = f;
  assign rsp.cond_met  = met;

endmodule

### src/cpu_alu_with_flags.sv
// SM83-style 8/16-bit ALU with flags. One transaction in carries an operation, two
// operands, a bit index, a condition code and the incoming Z/N/H/C flags; one
// transaction out carries the value, the new flags and whether the condition holds
// on the incoming flags. The block takes one transaction per cycle unless out_item.ready
// holds it back, and returns each result through one input register, a single pass of
// shallow add, shift and select logic, and one result register. The result register
// lets a new transaction enter while a finished one waits on out_item.ready.
module cpu_alu_with_flags (
  input  logic                 clk,
  input  logic                 rst_n,
  cpu_alu_req_if.sink          in_item,
  cpu_alu_rsp_if.source        out_item
);

  cpu_alu_pkg::alu_req_t s1_req_r;
  cpu_alu_pkg::alu_req_t s1_req_nxt;
  logic                  s1_valid_r;
  cpu_alu_pkg::alu_rsp_t s2_rsp_r;
  logic                  s2_valid_r;
  cpu_alu_pkg::alu_rsp_t core_rsp;
  logic                  s2_load;
  logic                  s1_load;

  assign s2_load = ~s2_valid_r | out_item.ready;
  assign s1_load = ~s1_valid_r | s2_load;
  assign in_item.ready = s1_load;

  always_comb begin
    s1_req_nxt.op          = cpu_alu_pkg::alu_op_t'(in_item.op);
    s1_req_nxt.a_value     = in_item.a_value;
    s1_req_nxt.b_value     = in_item.b_value;
    s1_req_nxt.bit_index   = in_item.bit_index;
    s1_req_nxt.update_zero = in_item.update_zero;
    s1_req_nxt.cond        = cpu_alu_pkg::alu_cond_t'(in_item.cond);
    s1_req_nxt.flags_in    = in_item.flags_in;
  end

  cpu_alu_core u_core (
    .req (s1_req_r),
    .rsp (core_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_valid_r <= in_item.valid;
      end
      if (s2_load) begin
        s2_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load && in_item.valid) begin
      s1_req_r <= s1_req_nxt;
    end
    if (s2_load && s1_valid_r) begin
      s2_rsp_r <= core_rsp;
    end
  end

  assign out_item.valid     = s2_valid_r;
  assign out_item.result    = s2_rsp_r.result;
  assign out_item.flags_out = s2_rsp_r.flags_out;
  assign out_item.cond_met  = s2_rsp_r.cond_met;

endmodule
